FILE: design/sps_pkg.sv
package sps_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int INDEX_BITS    = 20;
  localparam int COUNT_BITS    = INDEX_BITS + 1;
  localparam int FRAC_BITS     = 8;
  localparam int MAX_AVG       = 64;
  localparam int RING_AW       = $clog2(MAX_AVG);
  localparam int AVG_BITS      = RING_AW + 1;
  localparam int HALF_BITS     = RING_AW;
  localparam int VALUE_BITS    = SAMPLE_BITS + FRAC_BITS;
  localparam int ACC_BITS      = SAMPLE_BITS + RING_AW;
  localparam int SUM_BITS      = 36;
  localparam int NUM_BITS      = SUM_BITS + FRAC_BITS;
  localparam int DEN_BITS      = COUNT_BITS;
  localparam int DIV_CNT_BITS  = $clog2(NUM_BITS + 1);
  localparam int STATUS_BITS   = 2;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 21;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_BASE_LEVEL   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_START = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_END   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_AVG_POINTS   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_PEAK_MODE    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIRECTION    = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_TRACE_LENGTH = 3'd6;

  localparam logic [1:0] MODE_SEARCH = 2'd0;
  localparam logic [1:0] MODE_MEAN   = 2'd1;

  localparam logic [1:0] DIR_UP   = 2'd0;
  localparam logic [1:0] DIR_DOWN = 2'd1;
  localparam logic [1:0] DIR_ABS  = 2'd2;

  localparam logic [STATUS_BITS-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_BAD_WINDOW = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_DISABLED   = 2'd2;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] base_level;
    logic [INDEX_BITS-1:0]  window_start;
    logic [INDEX_BITS-1:0]  window_end;
    logic [AVG_BITS-1:0]    avg_points;
    logic [1:0]             peak_mode;
    logic [1:0]             direction;
    logic [COUNT_BITS-1:0]  trace_length;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last;
  } item_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0]  peak_value;
    logic [COUNT_BITS-1:0]  peak_index_x2;
    logic [STATUS_BITS-1:0] status;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STORE,
    ST_SUM,
    ST_DIV,
    ST_POST,
    ST_TAIL,
    ST_FIN,
    ST_RESULT
  } back_state_t;

endpackage

FILE: design/sps_ram.sv
module sps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/sps_front.sv
module sps_front import sps_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   last,
  output item_t                  item,
  output logic                   item_valid,
  input  logic                   item_pop
);

  item_t                 slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     fill;
  logic                  do_push;
  logic                  do_pop;

  assign full       = fill == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign item_valid = fill != '0;
  assign item       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = item_pop && item_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= '{sample: sample, last: last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

FILE: design/sps_div.sv
module sps_div import sps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [SUM_BITS-1:0]   sum,
  input  logic [DEN_BITS-1:0]   den,
  output logic                  done,
  output logic [VALUE_BITS-1:0] quot
);

  // restoring division of |sum| << FRAC_BITS, one quotient bit a cycle
  logic                    busy;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic                    neg;
  logic                    zero;
  logic [DEN_BITS-1:0]     den_r;
  logic [DEN_BITS-1:0]     rem;
  logic [NUM_BITS-1:0]     num;
  logic [SUM_BITS-1:0]     mag;
  logic [DEN_BITS:0]       rem_sh;
  logic                    ge;

  assign mag    = sum[SUM_BITS-1] ? (~sum + 1'b1) : sum;
  assign rem_sh = {rem, num[NUM_BITS-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_comb begin
    if (zero) begin
      quot = '0;
    end else if (neg) begin
      quot = ~num[VALUE_BITS-1:0] + 1'b1;
    end else begin
      quot = num[VALUE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg   <= sum[SUM_BITS-1];
      zero  <= den == '0;
      den_r <= den;
      rem   <= '0;
      num   <= {mag, {FRAC_BITS{1'b0}}};
    end else if (busy) begin
      rem <= ge ? DEN_BITS'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_BITS-1:0];
      num <= {num[NUM_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_BITS'(NUM_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: design/sps_back.sv
module sps_back import sps_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  item_t   item,
  input  logic    item_valid,
  output logic    item_pop,
  output result_t res,
  output logic    res_valid,
  input  logic    res_pop
);

  back_state_t state, state_next;

  logic [SAMPLE_BITS-1:0] x;
  logic                   lst;
  logic [COUNT_BITS-1:0]  k;
  logic [COUNT_BITS-1:0]  count;
  logic [SUM_BITS-1:0]    win_sum;
  logic [VALUE_BITS-1:0]  best_val;
  logic [INDEX_BITS-1:0]  best_idx;
  logic                   seeded;
  logic [ACC_BITS-1:0]    acc;
  logic [RING_AW-1:0]     j;
  logic [AVG_BITS-1:0]    rem_n;
  logic                   issued;
  logic [AVG_BITS-1:0]    avg_n;
  logic [INDEX_BITS-1:0]  cand_i;
  logic                   in_tail;
  logic [COUNT_BITS-1:0]  i_t;
  logic [COUNT_BITS-1:0]  n_tr;
  logic [VALUE_BITS-1:0]  mean_val;

  logic [AVG_BITS-1:0]    p;
  logic [HALF_BITS-1:0]   h;
  logic [COUNT_BITS-1:0]  llp1;
  logic [COUNT_BITS-1:0]  ulp;
  logic [COUNT_BITS-1:0]  llp;

  // per-sample classification
  logic                  in_tr;
  logic                  seeded_now;
  logic [COUNT_BITS:0]   kp1;
  logic [COUNT_BITS:0]   s_r;
  logic [COUNT_BITS:0]   i_r;
  logic                  run_ok;
  logic                  run_a;
  logic                  run_b;

  // end-of-trace sweep
  logic [COUNT_BITS-1:0] n_now;
  logic [COUNT_BITS:0]   lo_a;
  logic [COUNT_BITS-1:0] lo;
  logic                  tail_go;
  logic [COUNT_BITS-1:0] s_t;
  logic                  t_hit;

  logic                  bad;
  logic                  res_free;

  logic                  div_start;
  logic [SUM_BITS-1:0]   div_sum;
  logic [DEN_BITS-1:0]   div_den;
  logic                  div_done;
  logic [VALUE_BITS-1:0] quot;

  logic                  ram_we;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  logic [VALUE_BITS-1:0] bval;
  logic [VALUE_BITS:0]   dv;
  logic [VALUE_BITS:0]   dm;
  logic [VALUE_BITS:0]   av;
  logic [VALUE_BITS:0]   am;
  logic                  take;

  always_comb begin
    if (cfg.avg_points == '0) begin
      p = AVG_BITS'(1);
    end else if (cfg.avg_points > AVG_BITS'(MAX_AVG)) begin
      p = AVG_BITS'(MAX_AVG);
    end else begin
      p = cfg.avg_points;
    end
  end

  assign h    = HALF_BITS'((p - 1'b1) >> 1);
  assign llp  = {1'b0, cfg.window_start};
  assign ulp  = {1'b0, cfg.window_end};
  assign llp1 = llp + 1'b1;

  assign in_tr      = k < cfg.trace_length;
  assign seeded_now = seeded || (in_tr && k == llp);
  assign kp1        = {1'b0, k} + 1'b1;
  assign s_r        = kp1 - (COUNT_BITS+1)'(p);
  assign i_r        = s_r + (COUNT_BITS+1)'(h);
  assign run_ok     = in_tr && cfg.peak_mode == MODE_SEARCH && seeded_now
                      && kp1 >= (COUNT_BITS+1)'(p);
  assign run_a      = run_ok && s_r != '0 && i_r > {1'b0, llp} && i_r <= {1'b0, ulp};
  // first full run: every index up to h shares one average; first wins ties
  assign run_b      = run_ok && s_r == '0 && llp1 <= COUNT_BITS'(h) && llp1 <= ulp;

  assign n_now = (count < cfg.trace_length) ? count : cfg.trace_length;
  assign lo_a  = (n_now >= COUNT_BITS'(p))
                 ? ({1'b0, n_now} - (COUNT_BITS+1)'(p) + 1'b1) : '0;
  assign lo    = (lo_a < {1'b0, llp1}) ? llp1 : lo_a[COUNT_BITS-1:0];

  assign tail_go = cfg.peak_mode == MODE_SEARCH && seeded && n_tr != '0
                   && i_t <= ulp && i_t < n_tr;
  assign s_t     = (i_t > COUNT_BITS'(h)) ? (i_t - COUNT_BITS'(h)) : '0;
  assign t_hit   = ({1'b0, s_t} + (COUNT_BITS+1)'(p) - 1'b1) >= {1'b0, n_tr};

  assign bad      = cfg.window_start > cfg.window_end || ulp >= n_tr;
  assign res_free = !res_valid || res_pop;

  // candidate test against the running best, both taken from the baseline
  assign bval = {cfg.base_level, {FRAC_BITS{1'b0}}};
  assign dv   = {quot[VALUE_BITS-1], quot} - {bval[VALUE_BITS-1], bval};
  assign dm   = {best_val[VALUE_BITS-1], best_val} - {bval[VALUE_BITS-1], bval};
  assign av   = dv[VALUE_BITS] ? (~dv + 1'b1) : dv;
  assign am   = dm[VALUE_BITS] ? (~dm + 1'b1) : dm;

  always_comb begin
    case (cfg.direction)
      DIR_UP:   take = $signed(dv) > $signed(dm);
      DIR_DOWN: take = $signed(dv) < $signed(dm);
      DIR_ABS:  take = av > am;
      default:  take = 1'b0;
    endcase
  end

  assign ram_we = state == ST_STORE && in_tr;

  sps_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_AVG)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (k[RING_AW-1:0]),
    .wdata (x),
    .raddr (j),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (state == ST_FIN) begin
      div_sum = win_sum;
      div_den = DEN_BITS'(ulp - llp + 1'b1);
    end else begin
      div_sum = SUM_BITS'($signed(acc));
      div_den = DEN_BITS'(avg_n);
    end
  end

  sps_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .sum   (div_sum),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_pop   = 1'b0;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          item_pop   = 1'b1;
          state_next = ST_STORE;
        end
      end
      ST_STORE: begin
        state_next = (run_a || run_b) ? ST_SUM : ST_POST;
      end
      ST_SUM: begin
        if (rem_n == '0 && !issued) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = in_tail ? ST_TAIL : ST_POST;
        end
      end
      ST_POST: begin
        state_next = lst ? ST_TAIL : ST_IDLE;
      end
      ST_TAIL: begin
        if (!tail_go) begin
          state_next = ST_FIN;
        end else if (t_hit) begin
          state_next = ST_SUM;
        end
      end
      ST_FIN: begin
        if (!bad && cfg.peak_mode == MODE_MEAN) begin
          if (div_done) begin
            state_next = ST_RESULT;
          end else if (!in_tail) begin
            div_start = 1'b1;
          end
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (res_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          x   <= item.sample;
          lst <= item.last;
          k   <= count;
        end
      end
      ST_STORE: begin
        if (run_a || run_b) begin
          j       <= run_b ? '0 : s_r[RING_AW-1:0];
          rem_n   <= p;
          avg_n   <= p;
          issued  <= 1'b0;
          acc     <= '0;
          cand_i  <= run_b ? llp1[INDEX_BITS-1:0] : i_r[INDEX_BITS-1:0];
          in_tail <= 1'b0;
        end
      end
      ST_SUM: begin
        if (rem_n != '0) begin
          j      <= j + 1'b1;
          rem_n  <= rem_n - 1'b1;
          issued <= 1'b1;
        end else begin
          issued <= 1'b0;
        end
        if (issued) begin
          acc <= acc + ACC_BITS'($signed(ram_rdata));
        end
      end
      ST_POST: begin
        n_tr <= n_now;
        i_t  <= lo;
      end
      ST_TAIL: begin
        if (tail_go) begin
          i_t <= i_t + 1'b1;
          if (t_hit) begin
            j       <= s_t[RING_AW-1:0];
            rem_n   <= AVG_BITS'(n_tr - s_t);
            avg_n   <= AVG_BITS'(n_tr - s_t);
            issued  <= 1'b0;
            acc     <= '0;
            cand_i  <= i_t[INDEX_BITS-1:0];
            in_tail <= 1'b1;
          end
        end else begin
          // reused as "mean division launched" flag
          in_tail <= 1'b0;
        end
      end
      ST_FIN: begin
        if (div_start) begin
          in_tail <= 1'b1;
        end
        if (div_done) begin
          mean_val <= quot;
        end
      end
      default: ;
    endcase
  end

  // trace state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      win_sum   <= '0;
      best_val  <= '0;
      best_idx  <= '0;
      seeded    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_pop && res_valid && !(state == ST_RESULT && res_free)) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_STORE: begin
          if (count != COUNT_MAX) begin
            count <= count + 1'b1;
          end
          if (in_tr && k >= llp && k <= ulp) begin
            win_sum <= win_sum + SUM_BITS'($signed(x));
          end
          if (in_tr && k == llp) begin
            best_val <= {x, {FRAC_BITS{1'b0}}};
            best_idx <= cfg.window_start;
            seeded   <= 1'b1;
          end
        end
        ST_DIV: begin
          if (div_done && take) begin
            best_val <= quot;
            best_idx <= cand_i;
          end
        end
        ST_RESULT: begin
          if (res_free) begin
            res_valid <= 1'b1;
            count     <= '0;
            win_sum   <= '0;
            best_val  <= '0;
            best_idx  <= '0;
            seeded    <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESULT && res_free) begin
      if (bad) begin
        res <= '{peak_value: '0, peak_index_x2: '0, status: STATUS_BAD_WINDOW};
      end else if (cfg.peak_mode == MODE_SEARCH) begin
        res <= '{peak_value: best_val, peak_index_x2: {best_idx, 1'b0},
                 status: STATUS_OK};
      end else if (cfg.peak_mode == MODE_MEAN) begin
        res <= '{peak_value: mean_val, peak_index_x2: llp + ulp, status: STATUS_OK};
      end else begin
        res <= '{peak_value: '0, peak_index_x2: '0, status: STATUS_DISABLED};
      end
    end
  end

endmodule

FILE: design/smoothed_peak_search_core.sv
// Back end: a sample with no candidate passes only the idle, store and post states; one
//   that completes an average also takes the ring read, then the divider.
// Trace end: up to avg_points extra averages, then one more division in mean mode.
// Throughput is set by the single shared radix-2 divider; the input queue keeps taking
//   samples until full while the back end works and while a result waits to be popped.
// Reset (rst, synchronous, active high) clears config, queue pointers, result valid and trace state.
module smoothed_peak_search_core import sps_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // sample transactions
  input  logic                     push,
  output logic                     full,
  input  logic [SAMPLE_BITS-1:0]   sample,
  input  logic                     last,
  // result transactions
  output logic                     empty,
  input  logic                     pop,
  output logic [VALUE_BITS-1:0]    peak_value,
  output logic [COUNT_BITS-1:0]    peak_index_x2,
  output logic [STATUS_BITS-1:0]   status,
  // register writes
  input  logic                     cfg_write,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  cfg_t    cfg;
  item_t   item;
  logic    item_valid;
  logic    item_pop;
  result_t res;
  logic    res_valid;

  // Register file, used live; user must make writes land only between transactions.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_level   <= '0;
      cfg.window_start <= '0;
      cfg.window_end   <= '0;
      cfg.avg_points   <= AVG_BITS'(1);
      cfg.peak_mode    <= MODE_SEARCH;
      cfg.direction    <= DIR_UP;
      cfg.trace_length <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BASE_LEVEL:   cfg.base_level   <= cfg_data[SAMPLE_BITS-1:0];
        REG_WINDOW_START: cfg.window_start <= cfg_data[INDEX_BITS-1:0];
        REG_WINDOW_END:   cfg.window_end   <= cfg_data[INDEX_BITS-1:0];
        REG_AVG_POINTS:   cfg.avg_points   <= cfg_data[AVG_BITS-1:0];
        REG_PEAK_MODE:    cfg.peak_mode    <= cfg_data[1:0];
        REG_DIRECTION:    cfg.direction    <= cfg_data[1:0];
        REG_TRACE_LENGTH: cfg.trace_length <= cfg_data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Front end: short input queue decoupling the producer from the sequencer.
  sps_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .sample     (sample),
    .last       (last),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop)
  );

  // Back end: ring store, window sums, divider and the running best.
  sps_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .res        (res),
    .res_valid  (res_valid),
    .res_pop    (pop)
  );

  assign empty         = !res_valid;
  assign peak_value    = res.peak_value;
  assign peak_index_x2 = res.peak_index_x2;
  assign status        = res.status;

endmodule
